// File: rtl/core/gn2_pkg.sv
package gn2_pkg;

	localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
	localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
	localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

	// pi/2 in Q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint signed ONE_Q30 = 64'sd1073741824;

	// gradient components are Q1.14
	localparam int GRAD_W = 16;
	localparam int SIN_W = 15;

	// reciprocals of the taylor steps 2n(2n+1), exact for numerators below 2^32
	localparam int RECIP_SHIFT = 41;
	localparam longint unsigned TAYLOR_RECIP [8] = '{
		((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6,
		((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20,
		((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42,
		((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72,
		((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110,
		((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156,
		((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210,
		((64'd1 << RECIP_SHIFT) + 64'd271) / 64'd272
	};

	typedef logic [31:0] hash_t;

	function automatic hash_t rot16(input hash_t v);
		return {v[15:0], v[31:16]};
	endfunction

	// quarter-wave sine of m steps, Q1.14, evaluated at elaboration to fill the table
	function automatic logic [SIN_W-1:0] quarter_sin(input int unsigned m,
		input int unsigned abits);
		longint unsigned r;
		longint unsigned x2;
		longint unsigned term;
		longint signed sum;
		logic [127:0] prod;
		r = (longint'(m) * HALF_PI_Q30) >> (abits - 2);
		x2 = (r * r) >> 30;
		term = r;
		sum = longint'(r);
		for (int n = 1; n <= 8; n++) begin
			// the scaled term stays below 2^32
			prod = 128'((term * x2) >> 30) * 128'(TAYLOR_RECIP[n-1]);
			term = 64'(prod >> RECIP_SHIFT);
			if ((n & 1) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > ONE_Q30) begin
			sum = ONE_Q30;
		end
		return SIN_W'((sum + 64'sd32768) >>> 16);
	endfunction

endpackage

// File: rtl/core/gradient_noise_2d.sv
// 2d gradient noise, one point per request.
// input channel: x_coord, y_coord in signed fixed point with FRAC_BITS
// fraction bits, qualified by in_valid; the block holds in_stall high
// while it cannot take a request.
// output channel: noise_value in signed Q2.13, saturated, qualified by
// out_valid; the downstream side raises out_stall to hold it.
// throughput: one request per cycle unless the output stalls, carried by the
// eleven register stages (integer split, three hash multiplies, gradient
// table lookup, two dot product steps, two blends of a product and a sum
// each, the last with the final rounding) that all advance together.
// the gradient table is a constant quarter-wave sine read eight times
// per cycle, four corners times sine and cosine.
// a stall while out_valid is high freezes every stage; in_stall follows it in the
// same cycle, so nothing is dropped or repeated.
// reset clears all stage valid bits; the table needs no setup, so the
// block takes requests in the first cycle after reset is released.
module gradient_noise_2d #(
	parameter int ANGLE_BITS = 10,
	parameter int FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] x_coord,
	input  logic signed [23:0] y_coord,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] noise_value
);

	localparam int IW = 25 - FRAC_BITS;          // cell corner
	localparam int FW = FRAC_BITS + 1;           // fraction
	localparam int DW = FRAC_BITS + 2;           // offset to a corner
	localparam int WW = 2 * FRAC_BITS + 2;       // w*w
	localparam int TW = FRAC_BITS + 4;           // 3-2w
	localparam int PW = 3 * FRAC_BITS + 6;       // (3-2w)w^2
	localparam int SM_SHR = (3 * FRAC_BITS > 16) ? 3 * FRAC_BITS - 16 : 0;
	localparam int SM_SHL = (3 * FRAC_BITS < 16) ? 16 - 3 * FRAC_BITS : 0;
	localparam int SEW = PW + SM_SHL + 1;
	localparam int SW = 20;                      // blend weight, Q16
	localparam int GPW = DW + gn2_pkg::GRAD_W;   // one dot product term
	localparam int DSW = GPW + 2;
	localparam int DOT_SHR = FRAC_BITS - 2;
	localparam int DOTW = 22;                    // dot product, Q16
	localparam int BPW = DOTW + 1 + SW;
	localparam int RW = 28;                      // row blend, Q16
	localparam int YPW = RW + 1 + SW;
	localparam int VW = 34;
	localparam int QUARTER = 1 << (ANGLE_BITS - 2);
	localparam int MW = ANGLE_BITS - 2;

	logic adv;
	logic [10:0] vld_q;

	assign adv = !(vld_q[10] && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[10];

	// gradient table
	logic [gn2_pkg::SIN_W-1:0] sin_tab [QUARTER+1];
	for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_tab
		assign sin_tab[gi] = gn2_pkg::quarter_sin(gi, ANGLE_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[9:0], in_valid};
		end
	end

	// stage 1: split into corner and fraction, truncating toward zero
	logic signed [IW-1:0] x0_s1, y0_s1;
	logic signed [FW-1:0] fx_s1, fy_s1;
	logic signed [24:0] xe, ye, xmag, ymag;
	logic [24:0] xint, yint;
	logic signed [FW-1:0] xfr, yfr;

	always_comb begin
		xe = 25'(x_coord);
		ye = 25'(y_coord);
		xmag = xe[24] ? -xe : xe;
		ymag = ye[24] ? -ye : ye;
		xint = 25'(xmag) >> FRAC_BITS;
		yint = 25'(ymag) >> FRAC_BITS;
		xfr = xe[24] ? -FW'({1'b0, xmag[FRAC_BITS-1:0]}) : FW'({1'b0, xmag[FRAC_BITS-1:0]});
		yfr = ye[24] ? -FW'({1'b0, ymag[FRAC_BITS-1:0]}) : FW'({1'b0, ymag[FRAC_BITS-1:0]});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s1 <= xe[24] ? -IW'(xint) : IW'(xint);
			y0_s1 <= ye[24] ? -IW'(yint) : IW'(yint);
			fx_s1 <= xfr;
			fy_s1 <= yfr;
		end
	end

	// stage 2: first hash multiply per column, w*w and 3-2w
	logic [31:0] ax_s2 [2];
	logic signed [IW-1:0] y0_s2;
	logic signed [FW-1:0] fx_s2, fy_s2;
	logic signed [WW-1:0] wwx_s2, wwy_s2;
	logic signed [TW-1:0] tx_s2, ty_s2;
	logic [31:0] cx0, cx1;
	localparam logic signed [TW-1:0] THREE = TW'(3) <<< FRAC_BITS;

	assign cx0 = 32'(x0_s1);
	assign cx1 = 32'(x0_s1) + 32'd1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s2[0] <= 32'(64'(cx0) * 64'(gn2_pkg::HASH_MUL_A));
			ax_s2[1] <= 32'(64'(cx1) * 64'(gn2_pkg::HASH_MUL_A));
			y0_s2 <= y0_s1;
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			wwx_s2 <= WW'(fx_s1) * WW'(fx_s1);
			wwy_s2 <= WW'(fy_s1) * WW'(fy_s1);
			tx_s2 <= THREE - (TW'(fx_s1) <<< 1);
			ty_s2 <= THREE - (TW'(fy_s1) <<< 1);
		end
	end

	// stage 3: second hash multiply per corner, smoothstep product
	// corner index: bit 0 picks x0/x1, bit 1 picks y0/y1
	logic [31:0] b_s3 [4];
	logic [31:0] ax_s3 [2];
	logic signed [FW-1:0] fx_s3, fy_s3;
	logic signed [PW-1:0] smx_s3, smy_s3;
	logic [31:0] bpre [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			bpre[i] = ((i >= 2) ? 32'(y0_s2) + 32'd1 : 32'(y0_s2))
				^ gn2_pkg::rot16(ax_s2[i % 2]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				b_s3[i] <= 32'(64'(bpre[i]) * 64'(gn2_pkg::HASH_MUL_B));
			end
			ax_s3 <= ax_s2;
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			smx_s3 <= PW'(tx_s2) * PW'(wwx_s2);
			smy_s3 <= PW'(ty_s2) * PW'(wwy_s2);
		end
	end

	// stage 4: last hash multiply, weights to Q16
	logic [31:0] h_s4 [4];
	logic signed [FW-1:0] fx_s4, fy_s4;
	logic signed [SW-1:0] sx_s4, sy_s4;
	logic [31:0] apre [4];
	logic signed [SEW-1:0] smxe, smye;
	localparam logic signed [SEW-1:0] SM_HALF =
		(SM_SHR > 0) ? (SEW'(1) <<< (SM_SHR > 0 ? SM_SHR - 1 : 0)) : SEW'(0);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			apre[i] = ax_s3[i % 2] ^ gn2_pkg::rot16(b_s3[i]);
		end
		smxe = ((SEW'(smx_s3) <<< SM_SHL) + SM_HALF) >>> SM_SHR;
		smye = ((SEW'(smy_s3) <<< SM_SHL) + SM_HALF) >>> SM_SHR;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				h_s4[i] <= 32'(64'(apre[i]) * 64'(gn2_pkg::HASH_MUL_C));
			end
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			sx_s4 <= SW'(smxe);
			sy_s4 <= SW'(smye);
		end
	end

	// stage 5: gradient lookup with quadrant symmetry
	logic signed [gn2_pkg::GRAD_W-1:0] gx_s5 [4], gy_s5 [4];
	logic signed [FW-1:0] fx_s5, fy_s5;
	logic signed [SW-1:0] sx_s5, sy_s5;
	logic signed [gn2_pkg::GRAD_W-1:0] gs [4], gc [4], gxn [4], gyn [4];
	logic [MW-1:0] mi [4];
	logic [MW:0] ci [4];
	logic [1:0] qd [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qd[i] = h_s4[i][31 -: 2];
			mi[i] = h_s4[i][31-2 -: MW];
			ci[i] = (MW+1)'(QUARTER) - (MW+1)'(mi[i]);
			gs[i] = gn2_pkg::GRAD_W'(sin_tab[mi[i]]);
			gc[i] = gn2_pkg::GRAD_W'(sin_tab[ci[i]]);
			case (qd[i])
				2'd0: begin
					gxn[i] = gs[i];
					gyn[i] = gc[i];
				end
				2'd1: begin
					gxn[i] = gc[i];
					gyn[i] = -gs[i];
				end
				2'd2: begin
					gxn[i] = -gs[i];
					gyn[i] = -gc[i];
				end
				default: begin
					gxn[i] = -gc[i];
					gyn[i] = gs[i];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s5 <= gxn;
			gy_s5 <= gyn;
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
			sx_s5 <= sx_s4;
			sy_s5 <= sy_s4;
		end
	end

	// stage 6: offset times gradient
	logic signed [GPW-1:0] px_s6 [4], py_s6 [4];
	logic signed [SW-1:0] sx_s6, sy_s6;
	logic signed [DW-1:0] dxo [4], dyo [4];
	localparam logic signed [DW-1:0] ONE_D = DW'(1) <<< FRAC_BITS;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			dxo[i] = (i % 2 == 1) ? DW'(fx_s5) - ONE_D : DW'(fx_s5);
			dyo[i] = (i >= 2) ? DW'(fy_s5) - ONE_D : DW'(fy_s5);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				px_s6[i] <= GPW'(dxo[i]) * GPW'(gx_s5[i]);
				py_s6[i] <= GPW'(dyo[i]) * GPW'(gy_s5[i]);
			end
			sx_s6 <= sx_s5;
			sy_s6 <= sy_s5;
		end
	end

	// stage 7: dot product rounded to Q16
	logic signed [DOTW-1:0] dot_s7 [4];
	logic signed [SW-1:0] sx_s7, sy_s7;
	logic signed [DSW-1:0] dsum [4];
	localparam logic signed [DSW-1:0] DOT_HALF = DSW'(1) <<< (DOT_SHR - 1);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			dsum[i] = (DSW'(px_s6[i]) + DSW'(py_s6[i]) + DOT_HALF) >>> DOT_SHR;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				dot_s7[i] <= DOTW'(dsum[i]);
			end
			sx_s7 <= sx_s6;
			sy_s7 <= sy_s6;
		end
	end

	// stage 8: x blend product for both rows
	logic signed [BPW-1:0] bx_s8 [2];
	logic signed [DOTW-1:0] d0_s8 [2];
	logic signed [SW-1:0] sy_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 2; r++) begin
				bx_s8[r] <= (BPW'(dot_s7[2*r+1]) - BPW'(dot_s7[2*r])) * BPW'(sx_s7);
				d0_s8[r] <= dot_s7[2*r];
			end
			sy_s8 <= sy_s7;
		end
	end

	// stage 9: rows
	logic signed [RW-1:0] row_s9 [2];
	logic signed [SW-1:0] sy_s9;
	logic signed [BPW-1:0] bxr [2];

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			bxr[r] = (bx_s8[r] + BPW'(32768)) >>> 16;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 2; r++) begin
				row_s9[r] <= RW'(d0_s8[r]) + RW'(bxr[r]);
			end
			sy_s9 <= sy_s8;
		end
	end

	// stage 10: y blend product
	logic signed [YPW-1:0] by_s10;
	logic signed [RW-1:0] r0_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			by_s10 <= (YPW'(row_s9[1]) - YPW'(row_s9[0])) * YPW'(sy_s9);
			r0_s10 <= row_s9[0];
		end
	end

	// stage 11: final blend, Q16 to Q13, saturate
	logic signed [VW-1:0] vq16, vq13;
	logic signed [YPW-1:0] byr;
	logic signed [15:0] sat;

	always_comb begin
		byr = (by_s10 + YPW'(32768)) >>> 16;
		vq16 = VW'(r0_s10) + VW'(byr);
		vq13 = (vq16 + VW'(4)) >>> 3;
		if (vq13 > VW'(32767)) begin
			sat = 16'sh7fff;
		end else if (vq13 < -VW'(32768)) begin
			sat = -16'sh8000;
		end else begin
			sat = 16'(vq13);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			noise_value <= sat;
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(noise_value))
		else $error("output changed under stall");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> vld_q[10:1] == $past(vld_q[9:0]))
		else $error("valid bits did not advance");
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q) && $stable(sx_s5) && $stable(sy_s9))
		else $error("pipeline moved while stalled");
`endif

endmodule
